// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant violated");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tgh_pkg.sv =====
// Shared types, constants and decode functions of the handle pool.
package tgh_pkg;

  // Pool sizes and the layout of the shared slot store
  localparam int BLOCK_SLOTS = 64;
  localparam int MIDI_SLOTS  = 32;
  localparam int AME_SLOTS   = 4;
  localparam int TOTAL_SLOTS = BLOCK_SLOTS + MIDI_SLOTS + AME_SLOTS;
  localparam int BLOCK_BASE  = 0;
  localparam int MIDI_BASE   = BLOCK_SLOTS;
  localparam int AME_BASE    = BLOCK_SLOTS + MIDI_SLOTS;
  localparam int ADDR_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int KIND_W   = 2;
  localparam int TAG_W    = 5;
  localparam int SLOT_W   = 8;
  localparam int SEQ_W    = 16;
  localparam int HANDLE_W = TAG_W + SLOT_W + SEQ_W;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = SLOT_W + 1;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // Pool codes, equal to the handle type tags
  localparam logic [KIND_W-1:0] POOL_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] POOL_BLOCK = 2'd1;
  localparam logic [KIND_W-1:0] POOL_MIDI  = 2'd2;
  localparam logic [KIND_W-1:0] POOL_AME   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_INVALID,
    ST_BADTYPE
  } status_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_LOOKUP,
    OP_BADTYPE,
    OP_INVALID
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC
  } back_state_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_t                   op;
    logic [KIND_W-1:0]     pool;
    logic [SLOT_W-1:0]     slot;
    logic [SEQ_W-1:0]      seq;
    logic [HANDLE_W-1:0]   handle;
  } cmd_t;

  // Map a handle type tag to a pool, POOL_NONE when unknown
  function automatic logic [KIND_W-1:0] tag_to_pool(input logic [TAG_W-1:0] tag);
    logic [KIND_W-1:0] pool;
    pool = POOL_NONE;
    if (tag == TAG_W'(POOL_BLOCK)) pool = POOL_BLOCK;
    else if (tag == TAG_W'(POOL_MIDI)) pool = POOL_MIDI;
    else if (tag == TAG_W'(POOL_AME)) pool = POOL_AME;
    return pool;
  endfunction

  // Number of slots in a pool
  function automatic logic [CNT_W-1:0] pool_count(input logic [KIND_W-1:0] pool);
    logic [CNT_W-1:0] cnt;
    unique case (pool)
      POOL_BLOCK: cnt = CNT_W'(BLOCK_SLOTS);
      POOL_MIDI:  cnt = CNT_W'(MIDI_SLOTS);
      POOL_AME:   cnt = CNT_W'(AME_SLOTS);
      default:    cnt = '0;
    endcase
    return cnt;
  endfunction

  // First address of a pool in the shared slot store
  function automatic logic [ADDR_W-1:0] pool_base(input logic [KIND_W-1:0] pool);
    logic [ADDR_W-1:0] base;
    unique case (pool)
      POOL_BLOCK: base = ADDR_W'(BLOCK_BASE);
      POOL_MIDI:  base = ADDR_W'(MIDI_BASE);
      POOL_AME:   base = ADDR_W'(AME_BASE);
      default:    base = '0;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/typed_generational_handle_pool.sv =====
// The back end works on one request at a time and finishes it before it takes the next, in a take /
// memory read / update sequence around the registered read of the slot sequence memory.
// Up to two requests wait in the command queue while the back end or the output stalls.
// Reset (synchronous, rst_n low) marks every slot free with sequence zero at once; no sweep.
// Top level: typed generational handle pool with decoupled front and back ends.
`include "assert_macros.svh"

module typed_generational_handle_pool (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgh_pkg::ACTION_W-1:0] in_action,
  input  logic [tgh_pkg::KIND_W-1:0]   in_pool_kind,
  input  logic [tgh_pkg::HANDLE_W-1:0] in_handle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tgh_pkg::STATUS_W-1:0] out_status,
  output logic [tgh_pkg::HANDLE_W-1:0] out_result_handle
);
  import tgh_pkg::*;

  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  // Classify incoming beats
  tgh_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_pool_kind (in_pool_kind),
    .in_handle    (in_handle),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // Buffer commands between the two ends
  tgh_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  // Execute against slot state
  tgh_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_handle (out_result_handle)
  );

  // Queue occupancy stays within its depth
  `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_count <= QCNT_W'(QDEPTH))
  // The back end only takes a command that is there
  `ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, q_pop, q_count != '0)
  // A fresh result follows a command that the back end took earlier
  `ASSERT_IMPLY(a_result_after_pop, clk, rst_n, $rose(out_valid), $past(q_pop, 3))

endmodule

// ===== rtl/tgh_front.sv =====
// Front end: accepts request beats and classifies them into commands.
module tgh_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgh_pkg::ACTION_W-1:0] in_action,
  input  logic [tgh_pkg::KIND_W-1:0]   in_pool_kind,
  input  logic [tgh_pkg::HANDLE_W-1:0] in_handle,
  input  logic                         q_full,
  output logic                         q_push,
  output tgh_pkg::cmd_t                q_cmd
);
  import tgh_pkg::*;

  logic [TAG_W-1:0]  tag;
  logic [KIND_W-1:0] hpool;

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign tag   = in_handle[HANDLE_W-1 -: TAG_W];
  assign hpool = tag_to_pool(tag);

  // Classify the request; handle checks that need slot state go to the back end
  always_comb begin
    q_cmd        = '0;
    q_cmd.op     = OP_INVALID;
    q_cmd.pool   = POOL_NONE;
    q_cmd.slot   = in_handle[SEQ_W +: SLOT_W];
    q_cmd.seq    = in_handle[SEQ_W-1:0];
    q_cmd.handle = in_handle;
    unique case (in_action) inside
      ACT_ALLOC: begin
        if (in_pool_kind == POOL_NONE) begin
          q_cmd.op = OP_BADTYPE;
        end else begin
          q_cmd.op   = OP_ALLOC;
          q_cmd.pool = in_pool_kind;
        end
      end
      ACT_FREE, ACT_LOOKUP: begin
        if (in_action == ACT_LOOKUP && in_handle == '0) begin
          q_cmd.op = OP_INVALID;
        end else if (hpool == POOL_NONE) begin
          q_cmd.op = OP_BADTYPE;
        end else if (CNT_W'(q_cmd.slot) >= pool_count(hpool)) begin
          q_cmd.op = OP_INVALID;
        end else begin
          q_cmd.op   = (in_action == ACT_FREE) ? OP_FREE : OP_LOOKUP;
          q_cmd.pool = hpool;
        end
      end
      default: begin
        q_cmd.op = OP_INVALID;
      end
    endcase
  end

endmodule

// ===== rtl/tgh_fifo.sv =====
// Short command queue between the front end and the back end.
module tgh_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  tgh_pkg::cmd_t              push_cmd,
  input  logic                       pop,
  output tgh_pkg::cmd_t              head_cmd,
  output logic                       full,
  output logic                       empty,
  output logic [tgh_pkg::QCNT_W-1:0] count
);
  import tgh_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign head_cmd = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tgh_back.sv =====
// Back end: slot state, sequence memory, command execution and result register.
module tgh_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  tgh_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tgh_pkg::STATUS_W-1:0] out_status,
  output logic [tgh_pkg::HANDLE_W-1:0] out_result_handle
);
  import tgh_pkg::*;

  back_state_t             state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic                    found_r, found_nxt;
  logic [TOTAL_SLOTS-1:0]  free_r, free_nxt;
  logic [TOTAL_SLOTS-1:0]  wr_r, wr_nxt;
  logic [SEQ_W-1:0]        seq_mem [TOTAL_SLOTS];
  logic [SEQ_W-1:0]        rdata_r;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  logic [HANDLE_W-1:0]     handle_r, handle_nxt;

  logic                    blk_found, midi_found, ame_found;
  logic [SLOT_W-1:0]       blk_slot, midi_slot, ame_slot;
  logic                    sel_found;
  logic [SLOT_W-1:0]       sel_slot;
  logic [SEQ_W-1:0]        cur_seq, new_seq;
  logic                    out_free;
  logic                    mem_we;

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_result_handle = handle_r;
  assign out_free          = !out_valid_r || !out_stall;

  // Find the lowest free slot of each pool
  always_comb begin
    blk_found = 1'b0;
    blk_slot  = '0;
    for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
      if (free_r[BLOCK_BASE + i]) begin
        blk_found = 1'b1;
        blk_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    midi_found = 1'b0;
    midi_slot  = '0;
    for (int i = MIDI_SLOTS - 1; i >= 0; i--) begin
      if (free_r[MIDI_BASE + i]) begin
        midi_found = 1'b1;
        midi_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ame_found = 1'b0;
    ame_slot  = '0;
    for (int i = AME_SLOTS - 1; i >= 0; i--) begin
      if (free_r[AME_BASE + i]) begin
        ame_found = 1'b1;
        ame_slot  = SLOT_W'(i);
      end
    end
  end

  // Pick the search result of the requested pool
  always_comb begin
    unique case (q_cmd.pool)
      POOL_BLOCK: begin
        sel_found = blk_found;
        sel_slot  = blk_slot;
      end
      POOL_MIDI: begin
        sel_found = midi_found;
        sel_slot  = midi_slot;
      end
      POOL_AME: begin
        sel_found = ame_found;
        sel_slot  = ame_slot;
      end
      default: begin
        sel_found = 1'b0;
        sel_slot  = '0;
      end
    endcase
  end

  // A slot never written still holds its reset sequence of zero
  assign cur_seq = wr_r[addr_r] ? rdata_r : '0;
  assign new_seq = cur_seq + 1'b1;

  // Sequence the command: take, read the slot, then update and report
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    wr_nxt        = wr_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    handle_nxt    = handle_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;

    // Drop the result once the beat is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.op == OP_ALLOC) begin
            cmd_nxt.slot = sel_slot;
            found_nxt    = sel_found;
            addr_nxt     = pool_base(q_cmd.pool) + ADDR_W'(sel_slot);
          end else begin
            found_nxt = 1'b1;
            addr_nxt  = pool_base(q_cmd.pool) + ADDR_W'(q_cmd.slot);
          end
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_INVALID;
          handle_nxt    = '0;
          case (cmd_r.op)
            OP_ALLOC: begin
              if (found_r) begin
                mem_we           = 1'b1;
                wr_nxt[addr_r]   = 1'b1;
                free_nxt[addr_r] = 1'b0;
                status_nxt       = ST_OK;
                handle_nxt       = {TAG_W'(cmd_r.pool), cmd_r.slot, new_seq};
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_FREE, OP_LOOKUP: begin
              if (!free_r[addr_r] && cur_seq == cmd_r.seq) begin
                status_nxt = ST_OK;
                handle_nxt = cmd_r.handle;
                if (cmd_r.op == OP_FREE) begin
                  free_nxt[addr_r] = 1'b1;
                end
              end
            end
            OP_BADTYPE: begin
              status_nxt = ST_BADTYPE;
            end
            default: begin
              status_nxt = ST_INVALID;
            end
          endcase
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      free_r      <= '1;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold command and result payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    handle_r <= handle_nxt;
  end

  // Sequence memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[addr_r] <= new_seq;
    end
    rdata_r <= seq_mem[addr_r];
  end

endmodule
